[rtl/core/lth_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lth_pkg
// Shared types, register codes and saturation helper for the lava heat block.
// ----------------------------------------------------------------------------
package lth_pkg;

  localparam int VAL_W = 24;

  localparam logic REG_ANAGLYPH  = 1'b0;
  localparam logic REG_THRESHOLD = 1'b1;

  localparam logic [15:0] THRESHOLD_RESET = 16'd328;

  localparam logic signed [VAL_W-1:0] SAT_MAX = 24'sh7FFFFF;
  localparam logic signed [VAL_W-1:0] SAT_MIN = 24'sh800000;

  typedef logic signed [VAL_W-1:0] val_t;

  typedef struct packed {
    logic bank;
    logic spawn;
    logic last;
  } lth_flags_t;

  typedef struct packed {
    logic clear_busy;
    logic idle;
  } lth_status_t;

  function automatic val_t sat24(input logic signed [47:0] v);
    if (v > 48'sh00_0000_7FFFFF) begin
      return SAT_MAX;
    end
    if (v < 48'shFF_FFFF_800000) begin
      return SAT_MIN;
    end
    return v[VAL_W-1:0];
  endfunction

endpackage

[rtl/core/lava_texture_heat_step_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lava_texture_heat_step_top
// Animated lava texture: one random value in, one colored pixel out.
// ----------------------------------------------------------------------------
// Each input transaction advances the texture by one pixel in column order
// and yields one pixel transaction. In the engine a pixel goes through a
// queue pop, nine window reads through the single read port of the heat
// memory, a wait state for the read data, then seven arithmetic stages and
// the output load, which waits while the output is stalled. A two-entry
// queue lets the front end take new values while the engine works. After
// reset a clearing pass over every heat-memory address zeroes the stores;
// no input is taken during it, while register writes are.
module lava_texture_heat_step_top #(
  parameter int GRID_SIDE     = 16,
  parameter int FRACTION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_random_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_pixel_index,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic        out_last_of_tick,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int XW = $clog2(GRID_SIDE);
  localparam int CW = $clog2(GRID_SIDE * GRID_SIDE);
  localparam int EW = 2 * XW + 4 + $bits(lth_pkg::lth_flags_t);
  localparam logic [CW+7:0] LAST_EXT = (CW+8)'(GRID_SIDE * GRID_SIDE - 1);

  logic          anaglyph_r;
  logic [15:0]   threshold_r;
  logic          cfg_wr;
  logic          q_push, q_full, q_pop, q_valid;
  logic [EW-1:0] q_in, q_out;
  lth_pkg::lth_status_t status;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      anaglyph_r  <= 1'b0;
      threshold_r <= lth_pkg::THRESHOLD_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        lth_pkg::REG_ANAGLYPH:  anaglyph_r  <= pwdata[0];
        lth_pkg::REG_THRESHOLD: threshold_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      lth_pkg::REG_ANAGLYPH:  prdata = {31'b0, anaglyph_r};
      lth_pkg::REG_THRESHOLD: prdata = {16'b0, threshold_r};
      default:                prdata = '0;
    endcase
  end

  lth_front #(
    .GRID_SIDE(GRID_SIDE),
    .XW(XW),
    .EW(EW)
  ) u_front (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_random_value(in_random_value),
    .threshold(threshold_r),
    .status(status),
    .q_full(q_full),
    .q_push(q_push),
    .q_data(q_in)
  );

  lth_queue #(
    .WIDTH(EW),
    .DEPTH(2)
  ) u_queue (
    .clk(clk),
    .rst_n(rst_n),
    .push(q_push),
    .push_data(q_in),
    .full(q_full),
    .pop(q_pop),
    .head_valid(q_valid),
    .head_data(q_out)
  );

  lth_back #(
    .GRID_SIDE(GRID_SIDE),
    .FRACTION_BITS(FRACTION_BITS),
    .XW(XW),
    .CW(CW),
    .EW(EW)
  ) u_back (
    .clk(clk),
    .rst_n(rst_n),
    .q_valid(q_valid),
    .q_data(q_out),
    .q_pop(q_pop),
    .anaglyph(anaglyph_r),
    .status(status),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_pixel_index(out_pixel_index),
    .out_red(out_red),
    .out_green(out_green),
    .out_blue(out_blue),
    .out_last_of_tick(out_last_of_tick)
  );

  a_no_input_during_clear: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> !status.clear_busy)
    else $error("input taken during clearing pass");

  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_of_tick |-> out_pixel_index == LAST_EXT[7:0])
    else $error("last of tick on wrong pixel");

  a_pop_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> status.idle && !status.clear_busy)
    else $error("queue popped while engine busy");

endmodule

[rtl/core/lth_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lth_queue
// Small FIFO between the classifying front end and the pixel engine.
// ----------------------------------------------------------------------------
module lth_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output logic [WIDTH-1:0] head_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]      count_r, count_nxt;

  assign full       = (count_r == (AW+1)'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[rtl/core/lth_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lth_front
// Accepts random values, tracks the visit position and bank, and classifies
// each pixel step (spawn, last, sine offsets) into a queue entry.
// ----------------------------------------------------------------------------
module lth_front #(
  parameter int GRID_SIDE = 16,
  parameter int XW        = 4,
  parameter int EW        = 15
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [15:0]       in_random_value,
  input  logic [15:0]       threshold,
  input  lth_pkg::lth_status_t status,
  input  logic              q_full,
  output logic              q_push,
  output logic [EW-1:0]     q_data
);

  logic [XW-1:0] x_r, x_nxt;
  logic [XW-1:0] y_r, y_nxt;
  logic          bank_r, bank_nxt;
  logic          last_c;
  logic signed [1:0] xo_c, yo_c;
  lth_pkg::lth_flags_t flags_c;

  function automatic logic signed [1:0] sine_off(input logic [XW-1:0] k);
    logic [31:0] a;
    a = 32'(k) * 32'd1000000;
    if (a >= 32'(156785 * GRID_SIDE) && a <= 32'(343215 * GRID_SIDE)) begin
      return 2'sd1;
    end
    if (a >= 32'(656785 * GRID_SIDE) && a <= 32'(843215 * GRID_SIDE)) begin
      return -2'sd1;
    end
    return 2'sd0;
  endfunction

  assign in_ready = !status.clear_busy && !q_full;
  assign q_push   = in_valid && in_ready;

  assign last_c = (x_r == XW'(GRID_SIDE-1)) && (y_r == XW'(GRID_SIDE-1));
  assign xo_c   = sine_off(y_r);
  assign yo_c   = sine_off(x_r);

  always_comb begin
    flags_c.bank  = bank_r;
    flags_c.spawn = (in_random_value < threshold);
    flags_c.last  = last_c;
  end

  assign q_data = {x_r, y_r, xo_c, yo_c, flags_c};

  always_comb begin
    x_nxt    = x_r;
    y_nxt    = y_r;
    bank_nxt = bank_r;
    if (q_push) begin
      if (y_r == XW'(GRID_SIDE-1)) begin
        y_nxt = '0;
        if (last_c) begin
          x_nxt    = '0;
          bank_nxt = !bank_r;
        end else begin
          x_nxt = x_r + 1'b1;
        end
      end else begin
        y_nxt = y_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r    <= '0;
      y_r    <= '0;
      bank_r <= 1'b0;
    end else begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      bank_r <= bank_nxt;
    end
  end

endmodule

[rtl/core/lth_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lth_back
// Pixel engine: owns the heat, glow and spark memories, gathers the window
// sums over nine reads, updates the stores and forms the color.
// ----------------------------------------------------------------------------
module lth_back #(
  parameter int GRID_SIDE     = 16,
  parameter int FRACTION_BITS = 16,
  parameter int XW            = 4,
  parameter int CW            = 8,
  parameter int EW            = 15
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  logic [EW-1:0]        q_data,
  output logic                 q_pop,
  input  logic                 anaglyph,
  output lth_pkg::lth_status_t status,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_pixel_index,
  output logic [7:0]           out_red,
  output logic [7:0]           out_green,
  output logic [7:0]           out_blue,
  output logic                 out_last_of_tick
);

  localparam int FB = FRACTION_BITS;
  localparam int HW = CW + 1;
  localparam longint ONE    = longint'(1) << FB;
  localparam longint K001   = (2 * ONE + 100) / 200;
  localparam longint K006   = (12 * ONE + 100) / 200;
  localparam longint K08    = (8 * ONE + 5) / 10;
  localparam longint K15F   = (3 * ONE) / 2;
  localparam longint K15    = (K15F > 8388607) ? 8388607 : K15F;
  localparam longint DIVM   = ((longint'(1) << 36) + 19) / 20;
  localparam longint DOFS   = 20 * (longint'(1) << 24);
  localparam logic [15:0] RCP100 = 16'd41944;

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_RD   = 4'd2;
  localparam logic [3:0] S_RDW  = 4'd3;
  localparam logic [3:0] S_M1   = 4'd4;
  localparam logic [3:0] S_M2   = 4'd5;
  localparam logic [3:0] S_M3   = 4'd6;
  localparam logic [3:0] S_M4   = 4'd7;
  localparam logic [3:0] S_M5   = 4'd8;
  localparam logic [3:0] S_M6   = 4'd9;
  localparam logic [3:0] S_M7   = 4'd10;
  localparam logic [3:0] S_OUT  = 4'd11;

  lth_pkg::val_t heat_mem [2**HW];
  lth_pkg::val_t glow_mem [2**CW];
  lth_pkg::val_t spark_mem[2**CW];

  logic [3:0]    state_r, state_nxt;
  logic [HW-1:0] clr_cnt_r;
  logic [3:0]    k_r;
  logic [1:0]    wx_r, wy_r;
  logic [XW-1:0] x_r, y_r;
  logic signed [1:0] xo_r, yo_r;
  lth_pkg::lth_flags_t flags_r;
  logic          rdv_r;
  logic [3:0]    rdk_r;
  lth_pkg::val_t heat_rd_r, glow_rd_r, spark_rd_r;
  logic signed [27:0] sum9_r;
  logic signed [25:0] sum4_r;
  lth_pkg::val_t glow_c_r, spark_c_r;
  logic [25:0]   q_r;
  logic signed [FB+26:0] p4_r;
  logic signed [FB+24:0] gain_r;
  logic [FB:0]   v_r;
  logic [2*FB+1:0] vv_r;
  logic [FB+7:0] r100_r;
  logic [7:0]    r_r, g_r, b_r;
  logic [FB:0]   uv2_r;
  logic [2*FB+1:0] u4_r;
  logic [7:0]    ar_r, ag_r, ab_r;
  logic          out_valid_r;
  logic [7:0]    out_idx_r, out_red_r, out_green_r, out_blue_r;
  logic          out_last_r;

  logic [XW-1:0] ent_x, ent_y;
  logic signed [1:0] ent_xo, ent_yo;
  lth_pkg::lth_flags_t ent_flags;

  logic [CW-1:0] cell_c, win_c, glw_c;
  logic          hm_we, gm_we;
  logic [HW-1:0] hm_wa, hm_ra;
  logic [CW-1:0] gm_wa, gm_ra;
  lth_pkg::val_t hm_wd, gm_wd, sm_wd;
  lth_pkg::val_t heat_c, glow_n_c, spark_n_c;
  logic [FB:0]   v_c;
  logic          out_load;

  assign {ent_x, ent_y, ent_xo, ent_yo, ent_flags} = q_data;

  function automatic logic [XW-1:0] wrap(input logic signed [XW+2:0] t);
    if (t < 0) begin
      return XW'(t + (XW+3)'(GRID_SIDE));
    end
    if (t >= (XW+3)'(GRID_SIDE)) begin
      return XW'(t - (XW+3)'(GRID_SIDE));
    end
    return XW'(t);
  endfunction

  function automatic logic [CW-1:0] cidx(input logic [XW-1:0] col, input logic [XW-1:0] row);
    return CW'(row) * CW'(GRID_SIDE) + CW'(col);
  endfunction

  always_comb begin
    logic signed [XW+2:0] tx, ty, gx, gy;
    logic gdx, gdy;
    tx  = $signed({3'b000, x_r}) + (XW+3)'($signed({1'b0, wx_r})) - (XW+3)'(1)
          + (XW+3)'(xo_r);
    ty  = $signed({3'b000, y_r}) + (XW+3)'($signed({1'b0, wy_r})) - (XW+3)'(1)
          + (XW+3)'(yo_r);
    gdx = (k_r == 4'd1) || (k_r == 4'd2);
    gdy = (k_r == 4'd2) || (k_r == 4'd3);
    gx  = $signed({3'b000, x_r}) + (XW+3)'(gdx);
    gy  = $signed({3'b000, y_r}) + (XW+3)'(gdy);
    cell_c = cidx(x_r, y_r);
    win_c  = cidx(wrap(tx), wrap(ty));
    glw_c  = cidx(wrap(gx), wrap(gy));
  end

  // store update and color clamp
  always_comb begin
    logic signed [26:0] hq;
    logic signed [FB+26:0] h4w;
    logic signed [27:0] h4;
    logic signed [FB+24:0] gsw;
    logic signed [27:0] gs;
    logic signed [24:0] h2;
    hq  = $signed({1'b0, q_r}) - 27'sd16777216;
    h4w = (p4_r + (FB+27)'(2 * ONE)) >>> (FB + 2);
    h4  = 28'(h4w);
    heat_c = lth_pkg::sat24(48'(hq) + 48'(h4));
    gsw = (gain_r + (FB+25)'(ONE / 2)) >>> FB;
    gs  = 28'(gsw);
    glow_n_c = lth_pkg::sat24(48'(glow_c_r) + 48'(gs));
    if (glow_n_c < 0) begin
      glow_n_c = '0;
    end
    if (flags_r.spawn) begin
      spark_n_c = 24'(K15);
    end else begin
      spark_n_c = lth_pkg::sat24(48'(spark_c_r) - 48'(K006));
    end
    h2 = {heat_c, 1'b0};
    if (h2 < 0) begin
      v_c = '0;
    end else if (26'(h2) > 26'(ONE)) begin
      v_c = (FB+1)'(ONE);
    end else begin
      v_c = (FB+1)'(h2);
    end
  end

  always_comb begin
    hm_we = 1'b0;
    gm_we = 1'b0;
    hm_wa = clr_cnt_r;
    gm_wa = clr_cnt_r[CW-1:0];
    hm_wd = '0;
    gm_wd = '0;
    sm_wd = '0;
    if (state_r == S_CLR) begin
      hm_we = 1'b1;
      gm_we = 1'b1;
    end else if (state_r == S_M2) begin
      hm_we = 1'b1;
      gm_we = 1'b1;
      hm_wa = {!flags_r.bank, cell_c};
      gm_wa = cell_c;
      hm_wd = heat_c;
      gm_wd = glow_n_c;
      sm_wd = spark_n_c;
    end
  end

  assign hm_ra = {flags_r.bank, win_c};
  assign gm_ra = glw_c;

  always_ff @(posedge clk) begin
    if (hm_we) begin
      heat_mem[hm_wa] <= hm_wd;
    end
    heat_rd_r <= heat_mem[hm_ra];
  end

  always_ff @(posedge clk) begin
    if (gm_we) begin
      glow_mem[gm_wa]  <= gm_wd;
      spark_mem[gm_wa] <= sm_wd;
    end
    glow_rd_r  <= glow_mem[gm_ra];
    spark_rd_r <= spark_mem[cell_c];
  end

  assign q_pop    = (state_r == S_IDLE) && q_valid;
  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLR:  if (clr_cnt_r == '1) state_nxt = S_IDLE;
      S_IDLE: if (q_valid) state_nxt = S_RD;
      S_RD:   if (k_r == 4'd8) state_nxt = S_RDW;
      S_RDW:  state_nxt = S_M1;
      S_M1:   state_nxt = S_M2;
      S_M2:   state_nxt = S_M3;
      S_M3:   state_nxt = S_M4;
      S_M4:   state_nxt = S_M5;
      S_M5:   state_nxt = S_M6;
      S_M6:   state_nxt = S_M7;
      S_M7:   state_nxt = S_OUT;
      S_OUT:  if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_cnt_r   <= '0;
      rdv_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      rdv_r <= (state_r == S_RD);
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    logic [2*FB+9:0] gfull;
    logic [2*FB+8:0] bfull;
    logic [14:0] sa, sg, sb;
    logic [30:0] pa, pg, pb;
    logic signed [30:0] us;
    logic [63:0] prod;
    rdk_r <= k_r;
    if (q_pop) begin
      x_r     <= ent_x;
      y_r     <= ent_y;
      xo_r    <= ent_xo;
      yo_r    <= ent_yo;
      flags_r <= ent_flags;
      k_r     <= '0;
      wx_r    <= '0;
      wy_r    <= '0;
      sum9_r  <= '0;
      sum4_r  <= '0;
    end
    if (state_r == S_RD) begin
      k_r <= k_r + 1'b1;
      if (wy_r == 2'd2) begin
        wy_r <= '0;
        wx_r <= wx_r + 1'b1;
      end else begin
        wy_r <= wy_r + 1'b1;
      end
    end
    if (rdv_r) begin
      sum9_r <= sum9_r + 28'(heat_rd_r);
      if (rdk_r < 4'd4) begin
        sum4_r <= sum4_r + 26'(glow_rd_r);
      end
      if (rdk_r == 4'd0) begin
        glow_c_r  <= glow_rd_r;
        spark_c_r <= spark_rd_r;
      end
    end
    if (state_r == S_M1) begin
      us     = (31'(sum9_r) <<< 1) + 31'sd10 + 31'(DOFS);
      prod   = 64'(30'(us)) * 64'(DIVM);
      q_r    <= 26'(prod >> 36);
      p4_r   <= sum4_r * (FB+1)'(K08);
      gain_r <= spark_c_r * (FB+1)'(K001);
    end
    if (state_r == S_M2) begin
      v_r <= v_c;
    end
    if (state_r == S_M3) begin
      vv_r   <= v_r * v_r;
      r100_r <= v_r * (FB+8)'(100);
    end
    if (state_r == S_M4) begin
      gfull = {vv_r, 8'b0} - (2*FB+10)'(vv_r);
      g_r   <= 8'(gfull >> (2 * FB));
      uv2_r <= (FB+1)'(vv_r >> FB);
      r_r   <= 8'(8'd155 + (FB+8)'(r100_r >> FB));
    end
    if (state_r == S_M5) begin
      u4_r <= uv2_r * uv2_r;
    end
    if (state_r == S_M6) begin
      bfull = {(2*FB+2)'(u4_r >> FB), 7'b0};
      b_r   <= 8'(bfull >> FB);
    end
    if (state_r == S_M7) begin
      sa = 15'(r_r) * 15'd30 + 15'(g_r) * 15'd59 + 15'(b_r) * 15'd11;
      sg = 15'(r_r) * 15'd30 + 15'(g_r) * 15'd70;
      sb = 15'(r_r) * 15'd30 + 15'(b_r) * 15'd70;
      pa = 31'(sa) * 31'(RCP100);
      pg = 31'(sg) * 31'(RCP100);
      pb = 31'(sb) * 31'(RCP100);
      ar_r <= 8'(pa >> 22);
      ag_r <= 8'(pg >> 22);
      ab_r <= 8'(pb >> 22);
    end
    if (out_load) begin
      out_idx_r   <= 8'({8'b0, cell_c});
      out_red_r   <= anaglyph ? ar_r : r_r;
      out_green_r <= anaglyph ? ag_r : g_r;
      out_blue_r  <= anaglyph ? ab_r : b_r;
      out_last_r  <= flags_r.last;
    end
  end

  always_comb begin
    status.clear_busy = (state_r == S_CLR);
    status.idle       = (state_r == S_IDLE);
  end

  assign out_valid        = out_valid_r;
  assign out_pixel_index  = out_idx_r;
  assign out_red          = out_red_r;
  assign out_green        = out_green_r;
  assign out_blue         = out_blue_r;
  assign out_last_of_tick = out_last_r;

endmodule
